// ===== rtl/shrl_pkg.sv =====
// Types, constants and codes shared by the restart limiter.
`default_nettype none

package shrl_pkg;

  localparam int UNITS = 16;
  localparam int UNIT_W = 4;
  localparam int HIST_DEPTH = 8;
  localparam int HIST_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int FILL_W = $clog2(HIST_DEPTH + 1);
  localparam int MEM_DEPTH = UNITS << HIST_W;
  localparam int MEM_AW = UNIT_W + HIST_W;

  localparam logic [2:0] ST_HEALTHY = 3'd0;
  localparam logic [2:0] ST_DEGRADED = 3'd1;
  localparam logic [2:0] ST_RESTARTING = 3'd2;
  localparam logic [2:0] ST_CRASH_LOOP = 3'd3;
  localparam logic [2:0] ST_DISABLED = 3'd4;

  localparam logic ACT_PROBE = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_RETRIES = 2'd1;
  localparam logic [1:0] CFG_AUTO = 2'd2;
  localparam logic [1:0] CFG_MASK = 2'd3;

  localparam logic [15:0] DEFAULT_WINDOW = 16'd60;
  localparam logic [3:0] DEFAULT_RETRIES = 4'd3;
  localparam logic [7:0] REPEAT_FAILURES = 8'd2;

  typedef struct packed {
    logic        action;
    logic [3:0]  unit_index;
    logic        probe_ok;
    logic        force_req;
    logic [31:0] now_seconds;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  health_state;
    logic [2:0]  previous_state;
    logic        state_changed;
    logic        launch_start;
    logic        granted;
    logic [7:0]  failure_count;
    logic [31:0] total_restarts;
    logic [3:0]  recent_restarts;
  } out_result_t;

endpackage

`default_nettype wire

// ===== rtl/service_health_restart_limiter.sv =====
// Restart limiter top level: unit table, restart time ring and prune sequencer.
//
// Usage: raise start with an item on in_item while busy is low; the item is
// taken at that edge and busy rises on the next cycle. Each item yields one
// result on out_result, shown for a single cycle with out_strobe high; the
// receiver cannot stall it, so it must take the result in that cycle.
// Probes on a disabled unit, passing probes and first failures are decided in
// the evaluate state, which registers their result. Items that prune the
// restart history walk the unit's ring through one read port and one shared
// subtract/compare unit: each entry is read and compared, the kept entries are
// packed to the ring's bottom, and the done state registers the result. The
// next item may be started in the cycle in which the previous result is shown.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once; write
// only while busy is low and no result is pending.
// Reset (rst_n low, synchronous) sets the registers to their defaults and
// clears every unit to healthy with zero counts and an empty history; the
// restart time memory itself is not cleared.

`default_nettype none

module service_health_restart_limiter import shrl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire in_item_t    in_item,
  output logic             out_strobe,
  output out_result_t      out_result,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_RD   = 6'b000100,
    S_CMP  = 6'b001000,
    S_WB   = 6'b010000,
    S_DONE = 6'b100000
  } fsm_t;

  fsm_t state_r, state_nxt;

  // configuration
  logic [15:0] window_r;
  logic [3:0]  retries_r;
  logic        auto_r;
  logic [15:0] mask_r;

  // captured item
  logic             act_r;
  logic [UNIT_W-1:0] unit_r;
  logic             ok_r;
  logic             force_r;
  logic [31:0]      now_r;

  // per-unit table
  logic [2:0]        ustate_r  [UNITS];
  logic [7:0]        ufail_r   [UNITS];
  logic [31:0]       ucount_r  [UNITS];
  logic [HIST_W-1:0] uhead_r   [UNITS];
  logic [FILL_W-1:0] ufill_r   [UNITS];

  logic              unit_we;
  logic [2:0]        ustate_nxt;
  logic [7:0]        ufail_nxt;
  logic [31:0]       ucount_nxt;
  logic [HIST_W-1:0] uhead_nxt;
  logic [FILL_W-1:0] ufill_nxt;

  // restart time ring memory
  logic [31:0]       time_mem [MEM_DEPTH];
  logic [31:0]       mem_rdata_r;
  logic              mem_we, mem_re;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata;

  // prune sequencer
  logic [FILL_W-1:0] i_r, i_nxt;
  logic [FILL_W-1:0] k_r, k_nxt;
  logic [FILL_W-1:0] j_r, j_nxt;
  logic [31:0]       kept_r [HIST_DEPTH];
  logic              kept_we;

  logic        out_strobe_r, out_strobe_nxt;
  out_result_t out_result_r, out_result_nxt;

  // current unit entry
  logic [2:0]        cur_state;
  logic [7:0]        cur_fail;
  logic [31:0]       cur_count;
  logic [HIST_W-1:0] cur_head;
  logic [FILL_W-1:0] cur_fill;

  logic [15:0]       win;
  logic [3:0]        lim;
  logic [7:0]        fail_inc;
  logic [31:0]       count_inc;
  logic [31:0]       age;
  logic              keep;
  logic              limit_hit;
  logic              room;
  logic              rec;
  logic [HIST_W:0]   pos_sum;
  logic [HIST_W-1:0] rd_pos;
  logic [2:0]        new_state;

  assign cur_state = ustate_r[unit_r];
  assign cur_fail  = ufail_r[unit_r];
  assign cur_count = ucount_r[unit_r];
  assign cur_head  = uhead_r[unit_r];
  assign cur_fill  = ufill_r[unit_r];

  assign win = (window_r == 16'd0) ? DEFAULT_WINDOW : window_r;
  assign lim = (retries_r == 4'd0) ? DEFAULT_RETRIES : retries_r;
  assign fail_inc  = (cur_fail == 8'hFF) ? cur_fail : cur_fail + 8'd1;
  assign count_inc = (cur_count == 32'hFFFF_FFFF) ? cur_count : cur_count + 32'd1;

  // shared age unit: modular subtract and compare against the window
  assign age  = now_r - mem_rdata_r;
  assign keep = (age <= {16'd0, win});

  assign limit_hit = (8'(k_r) >= 8'(lim));
  assign room      = (k_r < FILL_W'(HIST_DEPTH));
  assign rec       = (act_r == ACT_RESTART) ? (force_r || !limit_hit) : (!limit_hit && auto_r);

  // ring position of the i-th oldest entry
  assign pos_sum = {1'b0, cur_head} + (HIST_W + 1)'(i_r[HIST_W-1:0]);
  assign rd_pos  = (pos_sum >= (HIST_W + 1)'(HIST_DEPTH)) ?
                   HIST_W'(pos_sum - (HIST_W + 1)'(HIST_DEPTH)) : pos_sum[HIST_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    i_nxt          = i_r;
    k_nxt          = k_r;
    j_nxt          = j_r;
    kept_we        = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = {unit_r, HIST_W'(0)};
    mem_raddr      = {unit_r, rd_pos};
    mem_wdata      = now_r;
    unit_we        = 1'b0;
    ustate_nxt     = cur_state;
    ufail_nxt      = cur_fail;
    ucount_nxt     = cur_count;
    uhead_nxt      = cur_head;
    ufill_nxt      = cur_fill;
    new_state      = cur_state;
    out_strobe_nxt = 1'b0;
    out_result_nxt = out_result_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        i_nxt = '0;
        k_nxt = '0;
        j_nxt = '0;
        if (act_r == ACT_RESTART) begin
          state_nxt = S_RD;
        end else begin
          unit_we = 1'b1;
          priority if (!mask_r[unit_r]) begin
            new_state = ST_DISABLED;
          end else if (ok_r) begin
            new_state = ST_HEALTHY;
            ufail_nxt = 8'd0;
          end else if (fail_inc < REPEAT_FAILURES) begin
            new_state = ST_DEGRADED;
            ufail_nxt = fail_inc;
          end else begin
            // repeated failure: bank the count now, decide after the prune
            ufail_nxt = fail_inc;
            state_nxt = S_RD;
          end
          if (state_nxt != S_RD) begin
            ustate_nxt     = new_state;
            state_nxt      = S_IDLE;
            out_strobe_nxt = 1'b1;
            out_result_nxt.health_state    = new_state;
            out_result_nxt.previous_state  = cur_state;
            out_result_nxt.state_changed   = (new_state != cur_state);
            out_result_nxt.launch_start    = 1'b0;
            out_result_nxt.granted         = 1'b0;
            out_result_nxt.failure_count   = ufail_nxt;
            out_result_nxt.total_restarts  = cur_count;
            out_result_nxt.recent_restarts = 4'(cur_fill);
          end
        end
      end
      S_RD: begin
        if (i_r == cur_fill) begin
          j_nxt     = '0;
          state_nxt = (k_r == '0) ? S_DONE : S_WB;
        end else begin
          mem_re    = 1'b1;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (keep) begin
          kept_we = 1'b1;
          k_nxt   = FILL_W'(k_r + 1'b1);
        end
        i_nxt     = FILL_W'(i_r + 1'b1);
        state_nxt = S_RD;
      end
      S_WB: begin
        // pack kept times to the bottom of the ring
        mem_we    = 1'b1;
        mem_waddr = {unit_r, j_r[HIST_W-1:0]};
        mem_wdata = kept_r[j_r[HIST_W-1:0]];
        j_nxt     = FILL_W'(j_r + 1'b1);
        if (FILL_W'(j_r + 1'b1) == k_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        unit_we   = 1'b1;
        uhead_nxt = '0;
        ufill_nxt = k_r;
        if (act_r == ACT_RESTART) begin
          new_state = rec ? ST_RESTARTING : ST_CRASH_LOOP;
        end else begin
          new_state = limit_hit ? ST_CRASH_LOOP : ST_RESTARTING;
        end
        if (rec) begin
          mem_we     = 1'b1;
          mem_wdata  = now_r;
          ucount_nxt = count_inc;
          if (room) begin
            mem_waddr = {unit_r, k_r[HIST_W-1:0]};
            ufill_nxt = FILL_W'(k_r + 1'b1);
          end else begin
            // full: overwrite the oldest and advance the head
            mem_waddr = {unit_r, HIST_W'(0)};
            uhead_nxt = (HIST_DEPTH > 1) ? HIST_W'(1) : HIST_W'(0);
          end
        end
        ustate_nxt     = new_state;
        state_nxt      = S_IDLE;
        out_strobe_nxt = 1'b1;
        out_result_nxt.health_state    = new_state;
        out_result_nxt.previous_state  = cur_state;
        out_result_nxt.state_changed   = (new_state != cur_state);
        out_result_nxt.launch_start    = rec;
        out_result_nxt.granted         = rec && (act_r == ACT_RESTART);
        out_result_nxt.failure_count   = cur_fail;
        out_result_nxt.total_restarts  = ucount_nxt;
        out_result_nxt.recent_restarts = 4'(ufill_nxt);
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
      window_r     <= DEFAULT_WINDOW;
      retries_r    <= DEFAULT_RETRIES;
      auto_r       <= 1'b0;
      mask_r       <= 16'hFFFF;
      i_r          <= '0;
      k_r          <= '0;
      j_r          <= '0;
      for (int u = 0; u < UNITS; u++) begin
        ustate_r[u] <= ST_HEALTHY;
        ufail_r[u]  <= 8'd0;
        ucount_r[u] <= 32'd0;
        uhead_r[u]  <= '0;
        ufill_r[u]  <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
      i_r          <= i_nxt;
      k_r          <= k_nxt;
      j_r          <= j_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WINDOW:  window_r  <= cfg_wdata;
          CFG_RETRIES: retries_r <= cfg_wdata[3:0];
          CFG_AUTO:    auto_r    <= cfg_wdata[0];
          CFG_MASK:    mask_r    <= cfg_wdata;
          default:     ;
        endcase
      end
      if (unit_we) begin
        ustate_r[unit_r] <= ustate_nxt;
        ufail_r[unit_r]  <= ufail_nxt;
        ucount_r[unit_r] <= ucount_nxt;
        uhead_r[unit_r]  <= uhead_nxt;
        ufill_r[unit_r]  <= ufill_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
    if (state_r == S_IDLE && start) begin
      act_r   <= in_item.action;
      unit_r  <= in_item.unit_index;
      ok_r    <= in_item.probe_ok;
      force_r <= in_item.force_req;
      now_r   <= in_item.now_seconds;
    end
    if (kept_we) begin
      kept_r[k_r[HIST_W-1:0]] <= mem_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= time_mem[mem_raddr];
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_changed_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_result.state_changed ==
                    (out_result.health_state != out_result.previous_state)))
    else $error("state_changed disagrees with the states reported");

  a_grant_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_result.granted) |-> (out_result.launch_start &&
                                            out_result.health_state == ST_RESTARTING))
    else $error("granted restart without launch");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_result.recent_restarts <= 4'(HIST_DEPTH)))
    else $error("history fill beyond its depth");

endmodule

`default_nettype wire

// ===== verif/limiter_result_monitor.sv =====
`timescale 1ns / 1ps
// Restart limiter monitor: shadow unit table, queue of predicted results, field compare.
module limiter_result_monitor import shrl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  in_item_t    in_item,
  input  logic        out_strobe,
  input  out_result_t out_result,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int unsigned mismatches,
  output int unsigned awaited
);

  logic [15:0] window_cfg;
  logic [3:0]  retries_cfg;
  logic        auto_cfg;
  logic [15:0] enable_cfg;

  logic [2:0]        health [UNITS];
  logic [7:0]        fails [UNITS];
  logic [31:0]       restarts [UNITS];
  logic [31:0]       stamps [UNITS][HIST_DEPTH];
  logic [HIST_W-1:0] head [UNITS];
  logic [FILL_W-1:0] fill [UNITS];

  out_result_t reports_due [$];
  int unsigned errors = 0;

  // Keep only restart times whose age lies within the window, oldest first.
  function automatic void prune_window(input logic [3:0] u, input logic [31:0] now,
                                       input logic [31:0] win);
    logic [31:0] kept [HIST_DEPTH];
    logic [31:0] stamp;
    logic [31:0] age;
    int k;
    k = 0;
    for (int i = 0; i < int'(fill[u]); i++) begin
      stamp = stamps[u][(int'(head[u]) + i) % HIST_DEPTH];
      age = now - stamp;
      if (age <= win) begin
        kept[k] = stamp;
        k++;
      end
    end
    for (int i = 0; i < k; i++) stamps[u][i] = kept[i];
    head[u] = '0;
    fill[u] = FILL_W'(k);
  endfunction

  function automatic void log_restart(input logic [3:0] u, input logic [31:0] now);
    if (fill[u] < HIST_DEPTH) begin
      stamps[u][(int'(head[u]) + int'(fill[u])) % HIST_DEPTH] = now;
      fill[u] = fill[u] + 1'b1;
    end else begin
      // drop the oldest time
      stamps[u][head[u]] = now;
      head[u] = HIST_W'((int'(head[u]) + 1) % HIST_DEPTH);
    end
    if (restarts[u] != '1) restarts[u] = restarts[u] + 32'd1;
  endfunction

  function automatic out_result_t advance_unit(input in_item_t it);
    out_result_t r;
    logic [3:0]  u;
    logic [2:0]  was;
    logic [31:0] win;
    logic [3:0]  lim;
    logic        launch;
    logic        grant;
    u = it.unit_index;
    win = (window_cfg == '0) ? {16'd0, DEFAULT_WINDOW} : {16'd0, window_cfg};
    lim = (retries_cfg == '0) ? DEFAULT_RETRIES : retries_cfg;
    was = health[u];
    launch = 1'b0;
    grant = 1'b0;
    if (it.action == ACT_PROBE) begin
      if (!enable_cfg[u]) begin
        health[u] = ST_DISABLED;
      end else if (it.probe_ok) begin
        fails[u] = '0;
        health[u] = ST_HEALTHY;
      end else begin
        if (fails[u] != 8'hFF) fails[u] = fails[u] + 8'd1;
        if (fails[u] < REPEAT_FAILURES) begin
          health[u] = ST_DEGRADED;
        end else begin
          prune_window(u, it.now_seconds, win);
          if (fill[u] >= lim) begin
            health[u] = ST_CRASH_LOOP;
          end else begin
            health[u] = ST_RESTARTING;
            if (auto_cfg) begin
              log_restart(u, it.now_seconds);
              launch = 1'b1;
            end
          end
        end
      end
    end else begin
      prune_window(u, it.now_seconds, win);
      if (!it.force_req && fill[u] >= lim) begin
        health[u] = ST_CRASH_LOOP;
      end else begin
        log_restart(u, it.now_seconds);
        health[u] = ST_RESTARTING;
        launch = 1'b1;
        grant = 1'b1;
      end
    end
    r.health_state = health[u];
    r.previous_state = was;
    r.state_changed = (health[u] != was);
    r.launch_start = launch;
    r.granted = grant;
    r.failure_count = fails[u];
    r.total_restarts = restarts[u];
    r.recent_restarts = 4'(fill[u]);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_result_t want;
    if (!rst_n) begin
      window_cfg = DEFAULT_WINDOW;
      retries_cfg = DEFAULT_RETRIES;
      auto_cfg = 1'b0;
      enable_cfg = 16'hFFFF;
      for (int u = 0; u < UNITS; u++) begin
        health[u] = ST_HEALTHY;
        fails[u] = '0;
        restarts[u] = '0;
        head[u] = '0;
        fill[u] = '0;
        for (int i = 0; i < HIST_DEPTH; i++) stamps[u][i] = '0;
      end
      reports_due.delete();
    end else begin
      if (out_strobe) begin
        if (reports_due.size() == 0) begin
          $error("result with no item outstanding: %p", out_result);
          errors++;
        end else begin
          want = reports_due.pop_front();
          check_field("health_state", 32'(want.health_state), 32'(out_result.health_state));
          check_field("previous_state", 32'(want.previous_state),
                      32'(out_result.previous_state));
          check_field("state_changed", 32'(want.state_changed),
                      32'(out_result.state_changed));
          check_field("launch_start", 32'(want.launch_start), 32'(out_result.launch_start));
          check_field("granted", 32'(want.granted), 32'(out_result.granted));
          check_field("failure_count", 32'(want.failure_count),
                      32'(out_result.failure_count));
          check_field("total_restarts", want.total_restarts, out_result.total_restarts);
          check_field("recent_restarts", 32'(want.recent_restarts),
                      32'(out_result.recent_restarts));
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW:  window_cfg = cfg_wdata;
          CFG_RETRIES: retries_cfg = cfg_wdata[3:0];
          CFG_AUTO:    auto_cfg = cfg_wdata[0];
          CFG_MASK:    enable_cfg = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) reports_due = {reports_due, advance_unit(in_item)};
    end
    mismatches <= errors;
    awaited <= reports_due.size();
  end

endmodule

// ===== verif/tb_service_health_restart_limiter.sv =====
`timescale 1ns / 1ps
// Restart limiter testbench top: clock, reset, stimulus phases, settings and verdict.
module tb_service_health_restart_limiter;
  import shrl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_ITEMS = 210;
  localparam int BURST_ITEMS = 260;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_strobe;
  out_result_t out_result;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_WINDOW;
  logic [15:0] cfg_wdata = '0;

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  logic [31:0] wall_clock = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  service_health_restart_limiter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  limiter_result_monitor monitor_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_result (out_result),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic in_item_t scatter_item();
    in_item_t it;
    it.action = 1'($urandom_range(1));
    it.unit_index = 4'($urandom_range(15));
    it.probe_ok = 1'($urandom_range(1));
    it.force_req = 1'($urandom_range(1));
    it.now_seconds = $urandom();
    return it;
  endfunction

  // Hold start high until the item is taken; idle first at the phase's rate.
  task automatic submit(input in_item_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      in_item <= scatter_item();
      @(posedge clk);
    end
    in_item <= item;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic issue(input logic act, input int unsigned unit, input logic ok,
                       input logic frc, input logic [31:0] now);
    in_item_t it;
    it.action = act;
    it.unit_index = 4'(unit);
    it.probe_ok = ok;
    it.force_req = frc;
    it.now_seconds = now;
    submit(it);
  endtask

  // Drop start and wait until every result is in and the block is free.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_settings(input logic [15:0] win, input logic [15:0] retries,
                               input logic [15:0] restart_on_fail, input logic [15:0] mask);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WINDOW;
    cfg_wdata <= win;
    @(posedge clk);
    cfg_index <= CFG_RETRIES;
    cfg_wdata <= retries;
    @(posedge clk);
    cfg_index <= CFG_AUTO;
    cfg_wdata <= restart_on_fail;
    @(posedge clk);
    cfg_index <= CFG_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] w, r, a, m;
    int unsigned span;
    int unsigned base;
    int unsigned unit;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults: window 60, limit 3, no auto restart, all units enabled.
    issue(ACT_PROBE, 0, 1'b1, 1'b0, 32'd0);
    issue(ACT_PROBE, 0, 1'b0, 1'b0, 32'd5);
    issue(ACT_PROBE, 0, 1'b0, 1'b0, 32'd6);
    issue(ACT_RESTART, 0, 1'b0, 1'b0, 32'd10);
    issue(ACT_RESTART, 0, 1'b0, 1'b0, 32'd20);
    issue(ACT_RESTART, 0, 1'b0, 1'b0, 32'd30);
    issue(ACT_RESTART, 0, 1'b0, 1'b0, 32'd40);
    issue(ACT_RESTART, 0, 1'b0, 1'b1, 32'd40);
    issue(ACT_PROBE, 0, 1'b0, 1'b0, 32'd45);
    issue(ACT_PROBE, 0, 1'b0, 1'b0, 32'd200);
    issue(ACT_PROBE, 0, 1'b1, 1'b0, 32'd201);
    // a restart time ahead of now counts as very old
    issue(ACT_RESTART, 1, 1'b0, 1'b0, 32'd1000);
    issue(ACT_RESTART, 1, 1'b0, 1'b0, 32'd500);
    // age across the 32-bit wrap
    issue(ACT_RESTART, 15, 1'b0, 1'b0, 32'hFFFF_FFFF);
    issue(ACT_RESTART, 15, 1'b1, 1'b0, 32'd0);
    settle();

    // Unit 15 disabled, a limit that cannot be reached, auto restart on.
    load_settings(16'd0, 16'd15, 16'd1, 16'h7FFF);
    issue(ACT_PROBE, 15, 1'b1, 1'b0, 32'd3);
    issue(ACT_RESTART, 15, 1'b0, 1'b0, 32'd5);
    issue(ACT_PROBE, 15, 1'b0, 1'b0, 32'd6);
    for (int i = 0; i < 9; i++) issue(ACT_RESTART, 2, 1'b0, 1'b0, 32'd100 + 32'(i));
    issue(ACT_PROBE, 2, 1'b0, 1'b0, 32'd110);
    issue(ACT_PROBE, 2, 1'b0, 1'b0, 32'd111);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin w = 16'd0; r = 16'd0; a = 16'd0; m = 16'hFFFF; end
        1: begin w = 16'd1; r = 16'd1; a = 16'd1; m = 16'hFFFF; end
        2: begin w = 16'hFFFF; r = 16'd8; a = 16'd1; m = 16'hFFFF; end
        3: begin w = 16'd15; r = 16'd15; a = 16'd1; m = 16'h0000; end
        4: begin
          w = 16'($urandom());
          r = 16'($urandom());
          a = 16'($urandom());
          m = 16'($urandom());
        end
        default: begin
          w = 16'($urandom_range(300, 1));
          r = 16'($urandom_range(8));
          a = 16'($urandom_range(1));
          m = 16'($urandom());
        end
      endcase
      load_settings(w, r, a, m);
      span = (w == 16'd0) ? 60 : int'(w);
      case (p % 4)
        1: sender_idle_pct = 77;
        3: sender_idle_pct = 33;
        default: sender_idle_pct = 0;
      endcase
      wall_clock = $urandom();
      base = $urandom_range(15);

      // Long run of failing probes drives the failure count into saturation.
      if (p == 2) begin
        for (int i = 0; i < BURST_ITEMS; i++) begin
          wall_clock = wall_clock + 32'd1;
          issue(ACT_PROBE, base, 1'b0, 1'b0, wall_clock);
        end
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 12) begin
          submit(scatter_item());
        end else begin
          wall_clock = wall_clock + 32'($urandom_range(span / 12 + 1));
          if ($urandom_range(49) == 0) wall_clock = wall_clock + 32'(span) + 32'd1;
          // occasionally step the clock back
          if ($urandom_range(99) == 0) wall_clock = wall_clock - 32'($urandom_range(1000, 1));
          unit = (base + $urandom_range(3)) % UNITS;
          if ($urandom_range(99) < 65)
            issue(ACT_PROBE, unit, $urandom_range(99) < 30, 1'($urandom_range(1)), wall_clock);
          else
            issue(ACT_RESTART, unit, 1'($urandom_range(1)), $urandom_range(99) < 15,
                  wall_clock);
        end
      end
      settle();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
